### src/q2e_pkg.sv
// Package for the quaternion to Euler angle unit.
// Holds fixed widths, the CORDIC arctangent table and shared helper types.
// Depends on nothing.
package q2e_pkg;

	localparam int QW = 16;
	localparam int AW = 16;
	// Products are Q4.28 and reach 2^32 after doubling and summing.
	localparam int PW = 36;
	// CORDIC datapath width: the vector grows by about 1.65 over the stages.
	localparam int CW = 40;
	localparam int ACCW = 34;
	localparam int TAB_LEN = 24;
	localparam int SQW = 58;
	localparam int RTW = 30;

	typedef logic signed [QW-1:0] quat_t;
	typedef logic signed [AW-1:0] angle_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [CW-1:0] cvec_t;
	typedef logic signed [ACCW-1:0] acc_t;

	typedef struct packed {
		cvec_t xs;
		cvec_t ys;
		acc_t  acc;
	} cordic_t;

	localparam acc_t PI_ACC = acc_t'(64'sd2147483648);
	localparam prod_t ONE_Q28 = prod_t'(64'sd268435456);
	localparam angle_t HALF_PI_OUT = angle_t'(16384);

	// atan(2^-i) in accumulator units where pi = 2^31.
	function automatic acc_t atan_tab(input int i);
		acc_t r;
		case (i)
			0: r = acc_t'(536870912);
			1: r = acc_t'(316933406);
			2: r = acc_t'(167458907);
			3: r = acc_t'(85004756);
			4: r = acc_t'(42667331);
			5: r = acc_t'(21354465);
			6: r = acc_t'(10679838);
			7: r = acc_t'(5340245);
			8: r = acc_t'(2670163);
			9: r = acc_t'(1335087);
			10: r = acc_t'(667544);
			11: r = acc_t'(333772);
			12: r = acc_t'(166886);
			13: r = acc_t'(83443);
			14: r = acc_t'(41722);
			15: r = acc_t'(20861);
			16: r = acc_t'(10430);
			17: r = acc_t'(5215);
			18: r = acc_t'(2608);
			19: r = acc_t'(1304);
			20: r = acc_t'(652);
			21: r = acc_t'(326);
			22: r = acc_t'(163);
			23: r = acc_t'(81);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round the accumulator (pi = 2^31) to a 16-bit binary angle.
	function automatic angle_t round_angle(input acc_t a);
		acc_t t;
		t = a + acc_t'(32768);
		return t[31:16];
	endfunction

endpackage

### src/q2e_if.sv
// Valid/ready channel interfaces for the quaternion to Euler angle unit.
// Depends on q2e_pkg.
interface q2e_in_if;
	logic valid;
	logic ready;
	q2e_pkg::quat_t quat_w;
	q2e_pkg::quat_t quat_x;
	q2e_pkg::quat_t quat_y;
	q2e_pkg::quat_t quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_out_if;
	logic valid;
	logic ready;
	q2e_pkg::angle_t yaw_angle;
	q2e_pkg::angle_t pitch_angle;
	q2e_pkg::angle_t roll_angle;
	logic pitch_saturated;
	modport source (output valid, yaw_angle, pitch_angle, roll_angle, pitch_saturated,
		input ready);
	modport sink (input valid, yaw_angle, pitch_angle, roll_angle, pitch_saturated,
		output ready);
endinterface

### src/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation cell with its output register.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic en,
	input  q2e_pkg::cordic_t d,
	output q2e_pkg::cordic_t q
);
	import q2e_pkg::*;

	cordic_t nxt;
	cvec_t dx, dy;

	// Rotate toward the x axis by atan(2^-STAGE).
	always_comb begin
		dx = d.ys >>> STAGE;
		dy = d.xs >>> STAGE;
		if (d.ys >= 0) begin
			nxt.xs = d.xs + dx;
			nxt.ys = d.ys - dy;
			nxt.acc = d.acc + atan_tab(STAGE);
		end else begin
			nxt.xs = d.xs - dx;
			nxt.ys = d.ys + dy;
			nxt.acc = d.acc - atan_tab(STAGE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

### src/q2e_isqrt_cell.sv
// One step of the digit-by-digit square root, two radicand bits per cell.
// Depends on q2e_pkg.
module q2e_isqrt_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [q2e_pkg::SQW-1:0] rem_d,
	input  logic [q2e_pkg::RTW-1:0] root_d,
	output logic [q2e_pkg::SQW-1:0] rem_q,
	output logic [q2e_pkg::RTW-1:0] root_q
);
	import q2e_pkg::*;

	localparam int SH = 2 * (RTW - 1 - STEP);
	logic [SQW+1:0] trial;
	logic [SQW+1:0] part;

	// Try to set the next root bit; keep it if the remainder stays positive.
	always_comb begin
		part = {2'b0, rem_d} >> SH;
		trial = {{(SQW-RTW){1'b0}}, root_d, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (part >= trial) begin
				rem_q <= rem_d - SQW'(trial << SH);
				root_q <= {root_d[RTW-2:0], 1'b1};
			end else begin
				rem_q <= rem_d;
				root_q <= {root_d[RTW-2:0], 1'b0};
			end
		end
	end
endmodule

### src/quaternion_to_euler_angles_unit.sv
// Quaternion (Q2.14) to yaw/pitch/roll binary angles, ZYX order.
// Pipeline: 4 stages for input, products, terms and 1 - s^2, 30 square-root cells, 1 setup,
// CORDIC_STAGES cordic cells (capped at TAB_LEN) and the rounding output register.
// Throughput is one item per cycle; the whole chain advances when the output
// register is free or being emptied. Reset clears the stage valid bits only.
// Depends on q2e_pkg, q2e_if, q2e_cordic_cell, q2e_isqrt_cell.
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	q2e_in_if.sink  in_ch,
	q2e_out_if.source out_ch
);
	import q2e_pkg::*;

	localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
	localparam int DEPTH = 3 + RTW + 1 + NS + 1;

	logic adv;
	logic [DEPTH-1:0] vld_q;

	// The chain moves when the output slot is empty or drained this cycle.
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
		end
	end

	// Stage 1: register inputs.
	quat_t w_s1, x_s1, y_s1, z_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= in_ch.quat_w;
			x_s1 <= in_ch.quat_x;
			y_s1 <= in_ch.quat_y;
			z_s1 <= in_ch.quat_z;
		end
	end

	// Stage 2: the ten products.
	prod_t ww_s2, xx_s2, yy_s2, zz_s2, wx_s2, yz_s2, wz_s2, xy_s2, wy_s2, zx_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s2 <= prod_t'(w_s1 * w_s1);
			xx_s2 <= prod_t'(x_s1 * x_s1);
			yy_s2 <= prod_t'(y_s1 * y_s1);
			zz_s2 <= prod_t'(z_s1 * z_s1);
			wx_s2 <= prod_t'(w_s1 * x_s1);
			yz_s2 <= prod_t'(y_s1 * z_s1);
			wz_s2 <= prod_t'(w_s1 * z_s1);
			xy_s2 <= prod_t'(x_s1 * y_s1);
			wy_s2 <= prod_t'(w_s1 * y_s1);
			zx_s2 <= prod_t'(z_s1 * x_s1);
		end
	end

	// Stage 3: sine and cosine terms.
	prod_t rs_s3, rc_s3, ys_s3, yc_s3, sp_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			rs_s3 <= (wx_s2 + yz_s2) <<< 1;
			rc_s3 <= ww_s2 - xx_s2 - yy_s2 + zz_s2;
			ys_s3 <= (wz_s2 + xy_s2) <<< 1;
			yc_s3 <= ww_s2 + xx_s2 - yy_s2 - zz_s2;
			sp_s3 <= (wy_s2 - zx_s2) <<< 1;
		end
	end

	// Stage 4: 1 - s^2 and the saturation decision.
	prod_t rs_s4, rc_s4, ys_s4, yc_s4, sp_s4;
	logic sat_s4, neg_s4;
	logic [SQW-1:0] rad_s4;
	logic [27:0] spm;
	always_comb begin
		spm = sp_s3[35] ? 28'(-sp_s3) : sp_s3[27:0];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rs_s4 <= rs_s3;
			rc_s4 <= rc_s3;
			ys_s4 <= ys_s3;
			yc_s4 <= yc_s3;
			sp_s4 <= sp_s3;
			sat_s4 <= (sp_s3 >= ONE_Q28) || (sp_s3 <= -ONE_Q28);
			neg_s4 <= sp_s3[35];
			rad_s4 <= (SQW'(1) << 56) - SQW'(spm * spm);
		end
	end

	// Square-root cell row; the other terms ride alongside in delay taps.
	logic [SQW-1:0] rem_t [RTW+1];
	logic [RTW-1:0] root_t [RTW+1];
	prod_t rs_d [RTW+1], rc_d [RTW+1], ys_d [RTW+1], yc_d [RTW+1], sp_d [RTW+1];
	logic sat_d [RTW+1];
	logic neg_d [RTW+1];
	assign rem_t[0] = rad_s4;
	assign root_t[0] = '0;
	assign rs_d[0] = rs_s4;
	assign rc_d[0] = rc_s4;
	assign ys_d[0] = ys_s4;
	assign yc_d[0] = yc_s4;
	assign sp_d[0] = sp_s4;
	assign sat_d[0] = sat_s4;
	assign neg_d[0] = neg_s4;

	for (genvar k = 0; k < RTW; k++) begin : g_sq
		q2e_isqrt_cell #(.STEP(k)) u_cell (
			.clk(clk), .en(adv),
			.rem_d(rem_t[k]), .root_d(root_t[k]),
			.rem_q(rem_t[k+1]), .root_q(root_t[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				rs_d[k+1] <= rs_d[k];
				rc_d[k+1] <= rc_d[k];
				ys_d[k+1] <= ys_d[k];
				yc_d[k+1] <= yc_d[k];
				sp_d[k+1] <= sp_d[k];
				sat_d[k+1] <= sat_d[k];
				neg_d[k+1] <= neg_d[k];
			end
		end
	end

	// Setup stage: zero-vector and left-half-plane pre-rotation.
	function automatic cordic_t pre_rot(input prod_t s, input prod_t c);
		cordic_t r;
		r.xs = cvec_t'(c);
		r.ys = cvec_t'(s);
		r.acc = '0;
		if (c < 0) begin
			r.acc = (s >= 0) ? PI_ACC : -PI_ACC;
			r.xs = -cvec_t'(c);
			r.ys = -cvec_t'(s);
		end
		return r;
	endfunction

	cordic_t cy [NS+1], cr [NS+1], cp [NS+1];
	logic zy_q [NS+1], zr_q [NS+1], sat_q [NS+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			cy[0] <= pre_rot(ys_d[RTW], yc_d[RTW]);
			cr[0] <= pre_rot(rs_d[RTW], rc_d[RTW]);
			cp[0] <= pre_rot(sp_d[RTW], prod_t'({1'b0, root_t[RTW]}));
			zy_q[0] <= (ys_d[RTW] == 0) && (yc_d[RTW] == 0);
			zr_q[0] <= (rs_d[RTW] == 0) && (rc_d[RTW] == 0);
			sat_q[0] <= sat_d[RTW];
		end
	end

	// Three parallel rows of CORDIC cells.
	for (genvar i = 0; i < NS; i++) begin : g_cor
		q2e_cordic_cell #(.STAGE(i)) u_y (.clk(clk), .en(adv), .d(cy[i]), .q(cy[i+1]));
		q2e_cordic_cell #(.STAGE(i)) u_r (.clk(clk), .en(adv), .d(cr[i]), .q(cr[i+1]));
		q2e_cordic_cell #(.STAGE(i)) u_p (.clk(clk), .en(adv), .d(cp[i]), .q(cp[i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				zy_q[i+1] <= zy_q[i];
				zr_q[i+1] <= zr_q[i];
				sat_q[i+1] <= sat_q[i];
			end
		end
	end

	// Rounding, pitch clamp and output register.
	angle_t pr;
	logic pneg;
	always_comb begin
		pr = round_angle(cp[NS].acc);
		pneg = neg_d[RTW];
	end

	logic sat_fin;
	angle_t pitch_fin;
	always_comb begin
		sat_fin = sat_q[NS];
		if (sat_fin) begin
			pitch_fin = HALF_PI_OUT;
		end else if (pr > HALF_PI_OUT) begin
			pitch_fin = HALF_PI_OUT;
		end else if (pr < -HALF_PI_OUT) begin
			pitch_fin = -HALF_PI_OUT;
		end else begin
			pitch_fin = pr;
		end
	end

	// Sign of pitch when saturated travels alongside the chain.
	logic sneg_q [NS+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			sneg_q[0] <= pneg;
		end
	end
	for (genvar j = 0; j < NS; j++) begin : g_sn
		always_ff @(posedge clk) begin
			if (adv) begin
				sneg_q[j+1] <= sneg_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.yaw_angle <= zy_q[NS] ? angle_t'(0) : round_angle(cy[NS].acc);
			out_ch.roll_angle <= zr_q[NS] ? angle_t'(0) : round_angle(cr[NS].acc);
			out_ch.pitch_saturated <= sat_fin;
			out_ch.pitch_angle <= sat_fin ? (sneg_q[NS] ? -HALF_PI_OUT : HALF_PI_OUT)
				: pitch_fin;
		end
	end
endmodule

### src/q2e_checker.sv
// Port-level checks for the quaternion to Euler angle unit, bound to the top.
// Depends on q2e_pkg.
module q2e_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] pitch_angle,
	input logic pitch_saturated
);
	// Pitch never leaves the quarter-turn range.
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384))
		else $error("pitch out of range");
	// A saturated pitch sits exactly at a quarter turn.
	a_sat_val: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pitch_saturated) |->
		(pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384))
		else $error("saturated pitch not clamped");
	// The input is taken whenever the output is not stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled without output back-pressure");
	// A stalled result stays valid and holds its pitch angle.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pitch_angle)))
		else $error("stalled result changed");
endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.pitch_angle(out_ch.pitch_angle), .pitch_saturated(out_ch.pitch_saturated)
);

### sim/q2e_angle_checker.sv
// Watches both channels of the quaternion to Euler angle unit, predicts every angle
// triple from the accepted quaternions and compares field by field.
// Depends on q2e_pkg and q2e_if.
module q2e_angle_checker #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	q2e_in_if    in_ch,
	q2e_out_if   out_ch,
	output int   fail_count,
	output int   angles_pending,
	output int   quats_seen,
	output int   sat_seen
);
	import q2e_pkg::*;

	typedef struct {
		angle_t yaw;
		angle_t pitch;
		angle_t roll;
		logic   sat;
	} euler_t;

	// Arctangent of 2^-i, with pi equal to 2^31.
	localparam longint ATAN_STEP [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	euler_t angles_q[$];

	// Floor integer square root, two bits per step.
	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	// Vectoring CORDIC arctangent, result with pi equal to 2^31.
	function automatic longint vector_angle(longint ys, longint xs);
		longint acc, dx, dy;
		int n;
		acc = 0;
		if (ys == 0 && xs == 0)
			return 0;
		// Left half plane: turn the vector by pi first.
		if (xs < 0) begin
			acc = (ys >= 0) ? 64'sd2147483648 : -64'sd2147483648;
			xs = -xs;
			ys = -ys;
		end
		n = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
		for (int i = 0; i < n; i++) begin
			dx = ys >>> i;
			dy = xs >>> i;
			if (ys >= 0) begin
				xs += dx;
				ys -= dy;
				acc += ATAN_STEP[i];
			end else begin
				xs -= dx;
				ys += dy;
				acc -= ATAN_STEP[i];
			end
		end
		return acc;
	endfunction

	function automatic longint to_binary_angle(longint acc);
		return (acc + 32768) >>> 16;
	endfunction

	function automatic euler_t quat_to_euler(quat_t qw, quat_t qx, quat_t qy, quat_t qz);
		longint w, x, y, z, s_pitch, p;
		euler_t e;
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		e.yaw = angle_t'(to_binary_angle(vector_angle(2 * (w * z + x * y),
			w * w + x * x - y * y - z * z)));
		e.roll = angle_t'(to_binary_angle(vector_angle(2 * (w * x + y * z),
			w * w - x * x - y * y + z * z)));
		s_pitch = 2 * (w * y - z * x);
		e.sat = 1'b0;
		if (s_pitch >= 64'sd268435456) begin
			p = 16384;
			e.sat = 1'b1;
		end else if (s_pitch <= -64'sd268435456) begin
			p = -16384;
			e.sat = 1'b1;
		end else begin
			p = to_binary_angle(vector_angle(s_pitch,
				floor_sqrt((64'd1 << 56) - longint'(s_pitch * s_pitch))));
			if (p > 16384)
				p = 16384;
			if (p < -16384)
				p = -16384;
		end
		e.pitch = angle_t'(p);
		return e;
	endfunction

	// Record expectations on input acceptance, compare on output acceptance.
	always @(posedge clk or negedge arst_n) begin
		euler_t want;
		if (!arst_n) begin
			angles_q.delete();
			fail_count = 0;
			angles_pending = 0;
			quats_seen = 0;
			sat_seen = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				want = quat_to_euler(in_ch.quat_w, in_ch.quat_x, in_ch.quat_y, in_ch.quat_z);
				angles_q.push_back(want);
				quats_seen++;
				if (want.sat)
					sat_seen++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (angles_q.size() == 0) begin
					$error("angle triple with no quaternion waiting");
					fail_count++;
				end else begin
					want = angles_q.pop_front();
					if (out_ch.yaw_angle !== want.yaw) begin
						$error("yaw_angle expected %0d actual %0d", want.yaw, out_ch.yaw_angle);
						fail_count++;
					end
					if (out_ch.pitch_angle !== want.pitch) begin
						$error("pitch_angle expected %0d actual %0d", want.pitch,
							out_ch.pitch_angle);
						fail_count++;
					end
					if (out_ch.roll_angle !== want.roll) begin
						$error("roll_angle expected %0d actual %0d", want.roll,
							out_ch.roll_angle);
						fail_count++;
					end
					if (out_ch.pitch_saturated !== want.sat) begin
						$error("pitch_saturated expected %0b actual %0b", want.sat,
							out_ch.pitch_saturated);
						fail_count++;
					end
				end
			end
			angles_pending = angles_q.size();
		end
	end

endmodule

### sim/tb_quaternion_to_euler_angles_unit.sv
// Top of the testbench: clock, reset, quaternion stimulus and the verdict.
// Depends on q2e_pkg, q2e_if, quaternion_to_euler_angles_unit and q2e_angle_checker.
module tb_quaternion_to_euler_angles_unit;
	import q2e_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 36;
	localparam int RANDOM_QUATS = 1500;

	logic clk;
	logic arst_n;
	logic quiet;
	int fail_count, angles_pending, quats_seen, sat_seen;

	q2e_in_if in_ch();
	q2e_out_if out_ch();

	quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	q2e_angle_checker #(.CORDIC_STAGES(STAGES)) checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .angles_pending(angles_pending),
		.quats_seen(quats_seen), .sat_seen(sat_seen));

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run limit, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	// Result side stalls at random except during the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= quiet || ($urandom_range(0, 99) >= 12);
		end
	end

	// Offer one quaternion, sometimes after a one-cycle gap, and hold it until accepted.
	task automatic send_quat(quat_t w, quat_t x, quat_t y, quat_t z);
		if (!quiet && $urandom_range(0, 99) < 12) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.quat_w <= w;
		in_ch.quat_x <= x;
		in_ch.quat_y <= y;
		in_ch.quat_z <= z;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// A random attitude scaled to roughly unit length.
	task automatic send_unit_quat();
		real a, b, c, d, norm;
		a = $urandom_range(0, 20000) - 10000.0;
		b = $urandom_range(0, 20000) - 10000.0;
		c = $urandom_range(0, 20000) - 10000.0;
		d = $urandom_range(0, 20000) - 10000.0;
		norm = $sqrt(a * a + b * b + c * c + d * d);
		if (norm < 1.0)
			norm = 1.0;
		norm = 16384.0 / norm;
		send_quat(quat_t'($rtoi(a * norm)), quat_t'($rtoi(b * norm)),
			quat_t'($rtoi(c * norm)), quat_t'($rtoi(d * norm)));
	endtask

	initial begin
		int k, pick;
		quat_t a;
		arst_n = 1'b0;
		quiet = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.quat_w = '0;
		in_ch.quat_x = '0;
		in_ch.quat_y = '0;
		in_ch.quat_z = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vector, identity, axis turns, extremes, pitch limits.
		send_quat(0, 0, 0, 0);
		send_quat(16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(-16384, 0, 0, 0);
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, -11585, 0, 0);
		send_quat(11585, 0, 0, -11585);
		send_quat(11585, 0, 11585, 0);
		send_quat(11586, 0, 11586, 0);
		send_quat(11586, 0, -11586, 0);
		send_quat(16384, 0, 16384, 0);
		send_quat(16384, 0, -16384, 0);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(-32768, 32767, -32768, 32767);
		send_quat(0, 0, -32768, 32767);
		send_quat(1, 0, 0, 0);
		send_quat(-1, 0, 0, -1);
		send_quat(0, -1, 1, 0);
		send_quat(0, 0, 0, -32768);

		// Random: mostly unit attitudes, mixed with raw patterns, small values and the pitch boundary.
		for (k = 0; k < RANDOM_QUATS; k++) begin
			quiet = (k >= 600 && k < 900);
			if (k == 1000) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (angles_pending != 0)
					@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_unit_quat();
			end else if (pick < 80) begin
				send_quat(quat_t'($urandom), quat_t'($urandom),
					quat_t'($urandom), quat_t'($urandom));
			end else if (pick < 90) begin
				send_quat(quat_t'($urandom_range(0, 15) - 8), quat_t'($urandom_range(0, 15) - 8),
					quat_t'($urandom_range(0, 15) - 8), quat_t'($urandom_range(0, 15) - 8));
			end else begin
				a = quat_t'($urandom_range(11570, 11600));
				send_quat($urandom_range(0, 1) ? a : -a, quat_t'($urandom_range(0, 7) - 4),
					$urandom_range(0, 1) ? a : -a, quat_t'($urandom_range(0, 7) - 4));
			end
		end
		quiet = 1'b1;
		in_ch.valid <= 1'b0;

		// Drain, then let the pipeline settle.
		while (angles_pending != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Checked %0d quaternions, %0d of them with clamped pitch.",
			quats_seen, sat_seen);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
